/* hdl/rrd_pkg.sv */
// Package for the reflect/refract direction block: fixed-point widths,
// pipeline latencies and the sideband structs carried along the cell chains.
// No dependencies.
`default_nettype none

package rrd_pkg;

    // Fraction bits of every Q2.F value.
    localparam int FRAC_BITS  = 14;
    localparam int ONE_Q      = 1 << FRAC_BITS;
    localparam int HALF_Q     = 1 << (FRAC_BITS - 1);
    localparam int DOT_LIM    = 2 << FRAC_BITS;

    localparam int IN_W       = 16;
    localparam int OUT_W      = 16;
    localparam int PROD_W     = 2 * IN_W;
    localparam int DSUM_W     = PROD_W + 2;
    localparam int DOT_W      = IN_W + 1;
    localparam int PND_W      = IN_W + DOT_W;
    localparam int DD_W       = 2 * DOT_W;
    localparam int RP_W       = 18;
    localparam int RV_W       = 19;
    localparam int A_W        = 18;
    localparam int K_W        = 18;
    localparam int NK_W       = IN_W + 1 + K_W;
    localparam int NKR_W      = 19;
    localparam int G_W        = 36;
    localparam int SQ_W       = G_W / 2;
    localparam int TP_W       = 35;
    localparam int VEC_W      = 36;

    // Normalizer: window of the largest magnitude, squares, root, quotient.
    localparam int NSH        = $clog2(VEC_W);
    localparam int TOP_W      = 31;
    localparam int SUM_W      = 2 * TOP_W + 2;
    localparam int LEN_W      = SUM_W / 2;
    localparam int NUM_W      = TOP_W + FRAC_BITS + 1;
    localparam int QUO_W      = FRAC_BITS + 1;

    localparam int NORM_LAT   = 1 + NSH + 2 + LEN_W + QUO_W + 1;
    localparam int TOTAL_LAT  = 6 + SQ_W + 2 + NORM_LAT;

    typedef struct packed {
        logic                         vld;
        logic [IN_W-1:0]              n;
        logic [2:0][IN_W-1:0]         nv;
        logic [2:0][A_W-1:0]          a;
        logic [2:0][RV_W-1:0]         rv;
    } t_g_sb;

    typedef struct packed {
        logic                         zero;
        logic [2:0]                   neg;
        logic [2:0][TOP_W-1:0]        top;
    } t_nrm_sb;

    typedef struct packed {
        logic                         zero;
        logic [2:0]                   neg;
    } t_div_sb;

endpackage

`default_nettype wire

/* hdl/rrd_sqrt_cell.sv */
// One registered step of a digit-by-digit integer square root: takes two
// radicand bits and produces one root bit. Sideband bits ride along.
// No package dependency.
`default_nettype none

module rrd_sqrt_cell #(
    parameter int W    = 64,
    parameter int SB_W = 1
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [W-1:0]      i_rad,
    input  logic [W/2+2:0]    i_rem,
    input  logic [W/2-1:0]    i_root,
    input  logic [SB_W-1:0]   i_sb,
    output logic [W-1:0]      o_rad,
    output logic [W/2+2:0]    o_rem,
    output logic [W/2-1:0]    o_root,
    output logic [SB_W-1:0]   o_sb
);
    localparam int HW = W / 2;
    localparam int RW = HW + 3;

    logic [RW-1:0] w_rem2;
    logic [RW-1:0] w_trial;
    logic [RW-1:0] n_rem;
    logic [HW-1:0] n_root;
    logic [W-1:0]  r_rad;
    logic [RW-1:0] r_rem;
    logic [HW-1:0] r_root;
    logic [SB_W-1:0] r_sb;

    always_comb begin
        w_rem2  = {i_rem[RW-3:0], i_rad[W-1:W-2]};
        w_trial = {1'b0, i_root, 2'b01};
        if (w_rem2 >= w_trial) begin
            n_rem  = w_rem2 - w_trial;
            n_root = {i_root[HW-2:0], 1'b1};
        end else begin
            n_rem  = w_rem2;
            n_root = {i_root[HW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= {i_rad[W-3:0], 2'b00};
            r_rem  <= n_rem;
            r_root <= n_root;
            r_sb   <= i_sb;
        end
    end

    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_sb   = r_sb;

endmodule

`default_nettype wire

/* hdl/rrd_div_cell.sv */
// One registered restoring-division step for three lanes sharing a divisor:
// produces one quotient bit per lane, most significant first.
// No package dependency.
`default_nettype none

module rrd_div_cell #(
    parameter int NUM_W = 46,
    parameter int DEN_W = 32,
    parameter int QW    = 15,
    parameter int SHIFT = 0,
    parameter int SB_W  = 1
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [2:0][NUM_W-1:0]      i_rem,
    input  logic [2:0][QW-1:0]         i_quo,
    input  logic [DEN_W-1:0]           i_den,
    input  logic [SB_W-1:0]            i_sb,
    output logic [2:0][NUM_W-1:0]      o_rem,
    output logic [2:0][QW-1:0]         o_quo,
    output logic [DEN_W-1:0]           o_den,
    output logic [SB_W-1:0]            o_sb
);
    logic [NUM_W-1:0]          w_dsh;
    logic [2:0][NUM_W-1:0]     n_rem;
    logic [2:0][QW-1:0]        n_quo;
    logic [2:0][NUM_W-1:0]     r_rem;
    logic [2:0][QW-1:0]        r_quo;
    logic [DEN_W-1:0]          r_den;
    logic [SB_W-1:0]           r_sb;

    always_comb begin
        w_dsh = NUM_W'(i_den) << SHIFT;
        for (int i = 0; i < 3; i++) begin
            if (i_rem[i] >= w_dsh) begin
                n_rem[i] = i_rem[i] - w_dsh;
                n_quo[i] = {i_quo[i][QW-2:0], 1'b1};
            end else begin
                n_rem[i] = i_rem[i];
                n_quo[i] = {i_quo[i][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_den <= i_den;
            r_sb  <= i_sb;
        end
    end

    assign o_rem = r_rem;
    assign o_quo = r_quo;
    assign o_den = r_den;
    assign o_sb  = r_sb;

endmodule

`default_nettype wire

/* hdl/rrd_norm.sv */
// Vector normalizer: sign/magnitude split, staged left-justify, sum of
// squares, square-root cell chain and division cell chain.
// Uses rrd_pkg, rrd_sqrt_cell and rrd_div_cell.
`default_nettype none

module rrd_norm (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [rrd_pkg::VEC_W-1:0]   i_vec [3],
    output logic signed [rrd_pkg::OUT_W-1:0]   o_vec [3]
);
    import rrd_pkg::*;

    logic [2:0][VEC_W-1:0] r_mag  [0:NSH];
    logic [2:0]            r_neg  [0:NSH];
    logic                  r_zero [0:NSH];
    logic [VEC_W-1:0]      w_or   [0:NSH-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_neg[0][i] <= i_vec[i][VEC_W-1];
                r_mag[0][i] <= i_vec[i][VEC_W-1] ? $unsigned(-i_vec[i])
                                                 : $unsigned(i_vec[i]);
            end
            r_zero[0] <= (i_vec[0] == '0) && (i_vec[1] == '0) && (i_vec[2] == '0);
        end
    end

    // Left-justify the largest magnitude in steps of 32, 16, ... 1 bits.
    for (genvar k = 0; k < NSH; k++) begin : g_shift
        localparam int SH = 1 << (NSH - 1 - k);
        assign w_or[k] = r_mag[k][0] | r_mag[k][1] | r_mag[k][2];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[k+1] <= r_zero[k];
                r_neg[k+1]  <= r_neg[k];
                for (int i = 0; i < 3; i++) begin
                    r_mag[k+1][i] <= (w_or[k][VEC_W-1 -: SH] == '0)
                                     ? (r_mag[k][i] << SH) : r_mag[k][i];
                end
            end
        end
    end

    logic [2:0][TOP_W-1:0]   w_top;
    logic [2:0][2*TOP_W-1:0] r_sq;
    logic [2:0][TOP_W-1:0]   r_sq_top;
    logic [2:0]              r_sq_neg;
    logic                    r_sq_zero;
    logic [SUM_W-1:0]        r_sum;
    t_nrm_sb                 r_sum_sb;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_top[i] = r_mag[NSH][i][VEC_W-1 -: TOP_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= w_top[i] * w_top[i];
            end
            r_sq_top  <= w_top;
            r_sq_neg  <= r_neg[NSH];
            r_sq_zero <= r_zero[NSH];
            r_sum <= SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
            r_sum_sb.zero <= r_sq_zero;
            r_sum_sb.neg  <= r_sq_neg;
            r_sum_sb.top  <= r_sq_top;
        end
    end

    localparam int NSB = $bits(t_nrm_sb);

    logic [SUM_W-1:0]   w_rad  [0:LEN_W];
    logic [LEN_W+2:0]   w_rem  [0:LEN_W];
    logic [LEN_W-1:0]   w_root [0:LEN_W];
    logic [NSB-1:0]     w_sb   [0:LEN_W];

    assign w_rad[0]  = r_sum;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_sb[0]   = r_sum_sb;

    for (genvar c = 0; c < LEN_W; c++) begin : g_sqrt
        rrd_sqrt_cell #(.W(SUM_W), .SB_W(NSB)) u_cell (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_rad  (w_rad[c]),
            .i_rem  (w_rem[c]),
            .i_root (w_root[c]),
            .i_sb   (w_sb[c]),
            .o_rad  (w_rad[c+1]),
            .o_rem  (w_rem[c+1]),
            .o_root (w_root[c+1]),
            .o_sb   (w_sb[c+1])
        );
    end

    localparam int DSB = $bits(t_div_sb);

    t_nrm_sb                 w_nsb;
    t_div_sb                 w_dsb0;
    logic [2:0][NUM_W-1:0]   w_drem [0:QUO_W];
    logic [2:0][QUO_W-1:0]   w_quo  [0:QUO_W];
    logic [LEN_W-1:0]        w_den  [0:QUO_W];
    logic [DSB-1:0]          w_dsb  [0:QUO_W];

    always_comb begin
        w_nsb       = t_nrm_sb'(w_sb[LEN_W]);
        w_dsb0.zero = w_nsb.zero;
        w_dsb0.neg  = w_nsb.neg;
        for (int i = 0; i < 3; i++) begin
            w_drem[0][i] = (NUM_W'(w_nsb.top[i]) << FRAC_BITS)
                         + NUM_W'(w_root[LEN_W] >> 1);
        end
    end

    assign w_quo[0] = '0;
    assign w_den[0] = w_root[LEN_W];
    assign w_dsb[0] = w_dsb0;

    for (genvar c = 0; c < QUO_W; c++) begin : g_div
        rrd_div_cell #(
            .NUM_W (NUM_W),
            .DEN_W (LEN_W),
            .QW    (QUO_W),
            .SHIFT (QUO_W - 1 - c),
            .SB_W  (DSB)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_rem (w_drem[c]),
            .i_quo (w_quo[c]),
            .i_den (w_den[c]),
            .i_sb  (w_dsb[c]),
            .o_rem (w_drem[c+1]),
            .o_quo (w_quo[c+1]),
            .o_den (w_den[c+1]),
            .o_sb  (w_dsb[c+1])
        );
    end

    t_div_sb                   w_osb;
    logic signed [OUT_W-1:0]   r_out [3];

    assign w_osb = t_div_sb'(w_dsb[QUO_W]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                if (w_osb.zero) begin
                    r_out[i] <= '0;
                end else if (w_osb.neg[i]) begin
                    r_out[i] <= -$signed(OUT_W'(w_quo[QUO_W][i]));
                end else begin
                    r_out[i] <= $signed(OUT_W'(w_quo[QUO_W][i]));
                end
            end
        end
    end

    assign o_vec = r_out;

endmodule

`default_nettype wire

/* hdl/reflect_refract_direction.sv */
// Top level of the mirror-reflection and Snell-refraction direction block.
// Uses rrd_pkg, rrd_sqrt_cell and rrd_norm.
`default_nettype none

// The block takes one ray hit per transfer (surface normal, incoming
// direction and the two refraction indices, all Q2.14) and returns one
// result per hit: the normalized mirror direction and the normalized
// refracted direction, with a flag that is low on total internal reflection
// (refracted fields then zero). It is a fully pipelined row of registered
// cells and accepts a new transfer in every cycle while the output is not
// stalled; each item passes the 18 root cells for the refraction term, the
// 32 root cells for the vector length and the 15 quotient cells of the
// normalizer. The whole pipe moves together: it advances whenever the
// output register is empty or its result is being taken, so a stalled
// output holds every stage in place and nothing is lost or repeated.
module reflect_refract_direction (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [rrd_pkg::IN_W-1:0]   i_normal_x,
    input  logic signed [rrd_pkg::IN_W-1:0]   i_normal_y,
    input  logic signed [rrd_pkg::IN_W-1:0]   i_normal_z,
    input  logic signed [rrd_pkg::IN_W-1:0]   i_incoming_x,
    input  logic signed [rrd_pkg::IN_W-1:0]   i_incoming_y,
    input  logic signed [rrd_pkg::IN_W-1:0]   i_incoming_z,
    input  logic        [rrd_pkg::IN_W-1:0]   i_index_from,
    input  logic        [rrd_pkg::IN_W-1:0]   i_index_to,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [rrd_pkg::OUT_W-1:0]  o_reflect_x,
    output logic signed [rrd_pkg::OUT_W-1:0]  o_reflect_y,
    output logic signed [rrd_pkg::OUT_W-1:0]  o_reflect_z,
    output logic signed [rrd_pkg::OUT_W-1:0]  o_refract_x,
    output logic signed [rrd_pkg::OUT_W-1:0]  o_refract_y,
    output logic signed [rrd_pkg::OUT_W-1:0]  o_refract_z,
    output logic                              o_refract_valid
);
    import rrd_pkg::*;

    // Global advance: the pipe moves when the last stage is free or drained.
    logic w_adv;
    logic r_vld [TOTAL_LAT];

    assign w_adv   = !r_vld[TOTAL_LAT-1] || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_vld[TOTAL_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < TOTAL_LAT; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (w_adv) begin
            r_vld[0] <= i_valid;
            for (int s = 1; s < TOTAL_LAT; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    logic signed [IN_W-1:0] w_nv [3];
    logic signed [IN_W-1:0] w_iv [3];

    assign w_nv[0] = i_normal_x;
    assign w_nv[1] = i_normal_y;
    assign w_nv[2] = i_normal_z;
    assign w_iv[0] = i_incoming_x;
    assign w_iv[1] = i_incoming_y;
    assign w_iv[2] = i_incoming_z;

    // Stage 1: the three products of the dot product N.I.
    logic signed [PROD_W-1:0] r1_p  [3];
    logic signed [IN_W-1:0]   r1_nv [3];
    logic signed [IN_W-1:0]   r1_iv [3];
    logic        [IN_W-1:0]   r1_n;
    logic        [IN_W-1:0]   r1_nt;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r1_p[i] <= w_nv[i] * w_iv[i];
            end
            r1_nv <= w_nv;
            r1_iv <= w_iv;
            r1_n  <= i_index_from;
            r1_nt <= i_index_to;
        end
    end

    // Stage 2: round the dot product back to QF and clamp it to +/-2.0.
    logic signed [DSUM_W-1:0] w_dsum;
    logic signed [DSUM_W-1:0] w_drnd;
    logic signed [DOT_W-1:0]  n2_d;
    logic signed [DOT_W-1:0]  r2_d;
    logic signed [IN_W-1:0]   r2_nv [3];
    logic signed [IN_W-1:0]   r2_iv [3];
    logic        [IN_W-1:0]   r2_n;
    logic        [IN_W-1:0]   r2_nt;

    always_comb begin
        w_dsum = DSUM_W'(r1_p[0]) + DSUM_W'(r1_p[1]) + DSUM_W'(r1_p[2]);
        w_drnd = (w_dsum + DSUM_W'(HALF_Q)) >>> FRAC_BITS;
        if (w_drnd > DSUM_W'(DOT_LIM)) begin
            n2_d = DOT_W'(DOT_LIM);
        end else if (w_drnd < -DSUM_W'(DOT_LIM)) begin
            n2_d = -DOT_W'(DOT_LIM);
        end else begin
            n2_d = DOT_W'(w_drnd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_d  <= n2_d;
            r2_nv <= r1_nv;
            r2_iv <= r1_iv;
            r2_n  <= r1_n;
            r2_nt <= r1_nt;
        end
    end

    // Stage 3: N*d per component and d*d.
    logic signed [PND_W-1:0] r3_pnd [3];
    logic signed [DD_W-1:0]  r3_dd;
    logic signed [IN_W-1:0]  r3_nv [3];
    logic signed [IN_W-1:0]  r3_iv [3];
    logic        [IN_W-1:0]  r3_n;
    logic        [IN_W-1:0]  r3_nt;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r3_pnd[i] <= r2_nv[i] * r2_d;
            end
            r3_dd <= r2_d * r2_d;
            r3_nv <= r2_nv;
            r3_iv <= r2_iv;
            r3_n  <= r2_n;
            r3_nt <= r2_nt;
        end
    end

    // Stage 4: mirror vector I - 2N(N.I), tangential part I - N(N.I), and
    // k = 1 - d^2.
    logic signed [RP_W-1:0] w_rp [3];
    logic signed [K_W-1:0]  w_ddr;
    logic signed [RV_W-1:0] r4_rv [3];
    logic signed [A_W-1:0]  r4_a  [3];
    logic signed [K_W-1:0]  r4_k;
    logic signed [IN_W-1:0] r4_nv [3];
    logic        [IN_W-1:0] r4_n;
    logic        [IN_W-1:0] r4_nt;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_rp[i] = RP_W'((r3_pnd[i] + PND_W'(HALF_Q)) >>> FRAC_BITS);
        end
        w_ddr = K_W'((r3_dd + DD_W'(HALF_Q)) >>> FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r4_rv[i] <= RV_W'(20'(r3_iv[i]) - (20'(w_rp[i]) <<< 1));
                r4_a[i]  <= A_W'(r3_iv[i]) - w_rp[i];
            end
            r4_k  <= K_W'(ONE_Q) - w_ddr;
            r4_nv <= r3_nv;
            r4_n  <= r3_n;
            r4_nt <= r3_nt;
        end
    end

    // Stage 5: n*k and nt^2.
    logic signed [NK_W-1:0] r5_nk;
    logic        [PROD_W-1:0] r5_ntt;
    logic signed [RV_W-1:0] r5_rv [3];
    logic signed [A_W-1:0]  r5_a  [3];
    logic signed [IN_W-1:0] r5_nv [3];
    logic        [IN_W-1:0] r5_n;
    logic                   r5_ntz;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r5_nk  <= $signed({1'b0, r4_n}) * r4_k;
            r5_ntt <= r4_nt * r4_nt;
            r5_rv  <= r4_rv;
            r5_a   <= r4_a;
            r5_nv  <= r4_nv;
            r5_n   <= r4_n;
            r5_ntz <= (r4_nt != '0);
        end
    end

    // Stage 6: g = nt^2 - n * rnd(n*k), the radicand of the refraction term.
    logic signed [NKR_W-1:0] w_nkr;
    logic signed [G_W-1:0]   w_ng;
    logic signed [G_W-1:0]   r6_g;
    logic signed [RV_W-1:0]  r6_rv [3];
    logic signed [A_W-1:0]   r6_a  [3];
    logic signed [IN_W-1:0]  r6_nv [3];
    logic        [IN_W-1:0]  r6_n;
    logic                    r6_ntz;

    always_comb begin
        w_nkr = NKR_W'((r5_nk + NK_W'(HALF_Q)) >>> FRAC_BITS);
        w_ng  = $signed({1'b0, r5_n}) * w_nkr;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r6_g   <= $signed({{(G_W-PROD_W){1'b0}}, r5_ntt}) - w_ng;
            r6_rv  <= r5_rv;
            r6_a   <= r5_a;
            r6_nv  <= r5_nv;
            r6_n   <= r5_n;
            r6_ntz <= r5_ntz;
        end
    end

    // Refraction exists only for a nonzero entered index and a positive g.
    // Without it the root chain gets zero and the vector is forced to zero.
    localparam int GSB = $bits(t_g_sb);

    t_g_sb            w_gsb0;
    logic             w_gok;
    logic [G_W-1:0]   w_grad  [0:SQ_W];
    logic [SQ_W+2:0]  w_grem  [0:SQ_W];
    logic [SQ_W-1:0]  w_groot [0:SQ_W];
    logic [GSB-1:0]   w_gsb   [0:SQ_W];

    always_comb begin
        w_gok      = r6_ntz && !r6_g[G_W-1] && (r6_g != '0);
        w_gsb0.vld = w_gok;
        w_gsb0.n   = r6_n;
        for (int i = 0; i < 3; i++) begin
            w_gsb0.nv[i] = r6_nv[i];
            w_gsb0.a[i]  = r6_a[i];
            w_gsb0.rv[i] = r6_rv[i];
        end
    end

    assign w_grad[0]  = w_gok ? $unsigned(r6_g) : '0;
    assign w_grem[0]  = '0;
    assign w_groot[0] = '0;
    assign w_gsb[0]   = w_gsb0;

    for (genvar c = 0; c < SQ_W; c++) begin : g_gsqrt
        rrd_sqrt_cell #(.W(G_W), .SB_W(GSB)) u_cell (
            .i_clk  (i_clk),
            .i_en   (w_adv),
            .i_rad  (w_grad[c]),
            .i_rem  (w_grem[c]),
            .i_root (w_groot[c]),
            .i_sb   (w_gsb[c]),
            .o_rad  (w_grad[c+1]),
            .o_rem  (w_grem[c+1]),
            .o_root (w_groot[c+1]),
            .o_sb   (w_gsb[c+1])
        );
    end

    // Stage P: n*(I - N d) and N*sqrt(g), one product per component each.
    t_g_sb                  w_gsbo;
    logic signed [TP_W-1:0] rp_pa [3];
    logic signed [TP_W-1:0] rp_pb [3];
    logic signed [RV_W-1:0] rp_rv [3];
    logic                   rp_vld;

    assign w_gsbo = t_g_sb'(w_gsb[SQ_W]);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                rp_pa[i] <= $signed({1'b0, w_gsbo.n}) * $signed(w_gsbo.a[i]);
                rp_pb[i] <= $signed(w_gsbo.nv[i]) * $signed({1'b0, w_groot[SQ_W]});
                rp_rv[i] <= $signed(w_gsbo.rv[i]);
            end
            rp_vld <= w_gsbo.vld;
        end
    end

    // Stage Q: the unnormalized refracted vector, zero on total reflection.
    logic signed [VEC_W-1:0] rq_tv [3];
    logic signed [VEC_W-1:0] rq_rv [3];
    logic                    rq_vld;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                rq_tv[i] <= rp_vld ? (VEC_W'(rp_pa[i]) - VEC_W'(rp_pb[i])) : '0;
                rq_rv[i] <= VEC_W'(rp_rv[i]);
            end
            rq_vld <= rp_vld;
        end
    end

    // Both vectors go through identical normalizers in lock step.
    logic signed [OUT_W-1:0] w_rout [3];
    logic signed [OUT_W-1:0] w_tout [3];

    rrd_norm u_norm_reflect (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_vec (rq_rv),
        .o_vec (w_rout)
    );

    rrd_norm u_norm_refract (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_vec (rq_tv),
        .o_vec (w_tout)
    );

    // The refraction flag waits out the normalizer latency.
    logic r_tvld [NORM_LAT];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_tvld[0] <= rq_vld;
            for (int s = 1; s < NORM_LAT; s++) begin
                r_tvld[s] <= r_tvld[s-1];
            end
        end
    end

    assign o_reflect_x     = w_rout[0];
    assign o_reflect_y     = w_rout[1];
    assign o_reflect_z     = w_rout[2];
    assign o_refract_x     = w_tout[0];
    assign o_refract_y     = w_tout[1];
    assign o_refract_z     = w_tout[2];
    assign o_refract_valid = r_tvld[NORM_LAT-1];

endmodule

`default_nettype wire
